// ===== src/smpq_pkg.sv =====
// Shared types, codes and name masks for the stable minimum priority queue.
package smpq_pkg;

   localparam int NAME_CHARS = 19;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_INSERTED = 2'd0,
      STATUS_REMOVED  = 2'd1,
      STATUS_EMPTY    = 2'd2,
      STATUS_FULL     = 2'd3
   } status_type;

   typedef struct packed {
      logic [15:0] score;
      logic [63:0] chars_low;
      logic [63:0] chars_mid;
      logic [23:0] chars_high;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic first;
      logic compare;
   } min_ctrl_type;

   function automatic logic [63:0] name_mask(input int base, input int nbytes);
      logic [63:0] m;
      m = '0;
      for (int i = 0; i < nbytes; i++) begin
         if (base + i < NAME_CHARS) begin
            m[8*i +: 8] = 8'hFF;
         end
      end
      return m;
   endfunction

   localparam logic [63:0] MASK_LOW  = name_mask(0, 8);
   localparam logic [63:0] MASK_MID  = name_mask(8, 8);
   localparam logic [23:0] MASK_HIGH = 24'(name_mask(16, 3));

endpackage

// ===== src/smpq_ram.sv =====
// Generic RAM with one write port and one registered read port.
module smpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/smpq_min_unit.sv =====
// Compare unit that tracks the earliest lowest-score entry of a scan.
module smpq_min_unit
   import smpq_pkg::*;
#(
   parameter int IW = 4
) (
   input  logic         clock,
   input  min_ctrl_type ctrl,
   input  logic [IW-1:0] cand_idx,
   input  entry_type    cand,
   output logic [IW-1:0] best_idx_in,
   output entry_type    best_entry
);

   logic [IW-1:0] best_idx_ff;
   entry_type     best_entry_ff;
   logic          take;

   // Strict less-than keeps the earliest entry among equal scores.
   assign take = ctrl.first
      || (ctrl.compare && ($signed(cand.score) < $signed(best_entry_ff.score)));
   assign best_idx_in = take ? cand_idx : best_idx_ff;

   always_ff @(posedge clock) begin
      if (take) begin
         best_idx_ff   <= cand_idx;
         best_entry_ff <= cand;
      end
   end

   assign best_entry = best_entry_ff;

endmodule

// ===== src/stable_min_priority_queue.sv =====
// Top level of the stable minimum priority queue: sequencer, store and result register.
// An insert, a refused insert or a remove on an empty store gives its result beat in the
// cycle after acceptance, and busy stays low, so such commands can follow every cycle.
// A remove raises busy while the sequencer first scans the N held entries for the
// earliest lowest score, then moves the later entries down one place a cycle, all
// through the single read port of the entry RAM.
// Reset clears state, count and rsp_valid; the RAM is not cleared, nor needs to be.
module stable_min_priority_queue
   import smpq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_opcode,
   input  logic signed [15:0] req_score,
   input  logic [63:0]        req_name_chars_0_7,
   input  logic [63:0]        req_name_chars_8_15,
   input  logic [23:0]        req_name_chars_16_18,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic signed [15:0] rsp_removed_score,
   output logic [63:0]        rsp_removed_chars_0_7,
   output logic [63:0]        rsp_removed_chars_8_15,
   output logic [23:0]        rsp_removed_chars_16_18,
   output logic [4:0]         rsp_occupancy
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COPY
   } state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   status_type    rsp_status_ff, rsp_status_in;
   entry_type     rsp_entry_ff, rsp_entry_in;
   logic [4:0]    rsp_occupancy_ff, rsp_occupancy_in;

   logic          ram_we;
   logic [IW-1:0] ram_waddr;
   entry_type     ram_wdata;
   logic [IW-1:0] ram_raddr;
   entry_type     rd_entry;
   entry_type     req_entry;

   min_ctrl_type  min_ctrl;
   logic [IW-1:0] best_idx_in;
   entry_type     best_entry;

   assign req_entry.score      = req_score;
   assign req_entry.chars_low  = req_name_chars_0_7 & MASK_LOW;
   assign req_entry.chars_mid  = req_name_chars_8_15 & MASK_MID;
   assign req_entry.chars_high = req_name_chars_16_18 & MASK_HIGH;

   smpq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (rd_entry)
   );

   smpq_min_unit #(
      .IW (IW)
   ) u_min (
      .clock       (clock),
      .ctrl        (min_ctrl),
      .cand_idx    (idx_ff),
      .cand        (rd_entry),
      .best_idx_in (best_idx_in),
      .best_entry  (best_entry)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      ram_we        = 1'b0;
      ram_waddr     = count_ff[IW-1:0];
      ram_wdata     = req_entry;
      ram_raddr     = IW'(idx_ff + IW'(1));
      min_ctrl      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            ram_raddr = '0;
            if (start) begin
               if (req_opcode == OP_INSERT) begin
                  rsp_valid_in = 1'b1;
                  rsp_entry_in = '0;
                  if (count_ff == CW'(DEPTH)) begin
                     rsp_status_in = STATUS_FULL;
                  end else begin
                     ram_we        = 1'b1;
                     count_in      = count_ff + CW'(1);
                     rsp_status_in = STATUS_INSERTED;
                  end
               end else if (count_ff == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_entry_in  = '0;
                  rsp_status_in = STATUS_EMPTY;
               end else begin
                  idx_in   = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            min_ctrl.first   = (idx_ff == '0);
            min_ctrl.compare = 1'b1;
            if (CW'(idx_ff) == count_ff - CW'(1)) begin
               idx_in    = best_idx_in;
               ram_raddr = IW'(best_idx_in + IW'(1));
               state_in  = ST_COPY;
            end else begin
               idx_in = IW'(idx_ff + IW'(1));
            end
         end
         ST_COPY: begin
            if (CW'(idx_ff) + CW'(1) < count_ff) begin
               ram_we    = 1'b1;
               ram_waddr = idx_ff;
               ram_wdata = rd_entry;
               ram_raddr = IW'(idx_ff + IW'(2));
               idx_in    = IW'(idx_ff + IW'(1));
            end else begin
               count_in      = count_ff - CW'(1);
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_REMOVED;
               rsp_entry_in  = best_entry;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_occupancy_in = rsp_valid_in ? 5'(count_in) : rsp_occupancy_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff           <= idx_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_entry_ff     <= rsp_entry_in;
      rsp_occupancy_ff <= rsp_occupancy_in;
   end

   assign busy                    = (state_ff != ST_IDLE);
   assign rsp_valid               = rsp_valid_ff;
   assign rsp_status              = rsp_status_ff;
   assign rsp_removed_score       = rsp_entry_ff.score;
   assign rsp_removed_chars_0_7   = rsp_entry_ff.chars_low;
   assign rsp_removed_chars_8_15  = rsp_entry_ff.chars_mid;
   assign rsp_removed_chars_16_18 = rsp_entry_ff.chars_high;
   assign rsp_occupancy           = rsp_occupancy_ff;

   // The entry count never exceeds the store depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count exceeds depth");

   // An accepted insert gives its result beat in the next cycle.
   a_insert_beat: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_opcode == OP_INSERT) |=>
         (rsp_valid && (rsp_status == STATUS_INSERTED || rsp_status == STATUS_FULL)))
      else $error("insert result beat missing");

   // A removal beat drops the entry count by exactly one.
   a_remove_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_REMOVED) |->
         (count_ff == CW'($past(count_ff) - CW'(1))))
      else $error("removal did not drop the count by one");

   // No result beat shows in the first busy cycle of a removal.
   a_remove_done: assert property (@(posedge clock) disable iff (reset)
      (busy && !$past(busy) && !$past(reset)) |-> !rsp_valid)
      else $error("result beat while a removal starts");

endmodule

// ===== verif/tb_stable_min_priority_queue.sv =====
// Self-checking testbench for the stable minimum priority queue: directed and random command beats.
module tb_stable_min_priority_queue;
   timeunit 1ns;
   timeprecision 1ps;

   import smpq_pkg::*;

   localparam int DEPTH = 16;

   typedef struct {
      status_type         status;
      logic signed [15:0] score;
      logic [63:0]        chars_low;
      logic [63:0]        chars_mid;
      logic [23:0]        chars_high;
      logic [4:0]         occupancy;
   } queue_outcome_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_opcode = OP_INSERT;
   logic signed [15:0] req_score = '0;
   logic [63:0]        req_name_chars_0_7 = '0;
   logic [63:0]        req_name_chars_8_15 = '0;
   logic [23:0]        req_name_chars_16_18 = '0;
   logic               rsp_valid;
   logic [1:0]         rsp_status;
   logic signed [15:0] rsp_removed_score;
   logic [63:0]        rsp_removed_chars_0_7;
   logic [63:0]        rsp_removed_chars_8_15;
   logic [23:0]        rsp_removed_chars_16_18;
   logic [4:0]         rsp_occupancy;

   entry_type         held_entries [DEPTH];
   int                held_count = 0;
   queue_outcome_type expected_outcomes [$];
   bit                back_to_back = 1'b0;
   int                error_count = 0;
   int                inserts_done = 0;
   int                removes_done = 0;
   int                full_refusals = 0;
   int                empty_removes = 0;

   stable_min_priority_queue #(.DEPTH(DEPTH)) dut (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_opcode             (req_opcode),
      .req_score              (req_score),
      .req_name_chars_0_7     (req_name_chars_0_7),
      .req_name_chars_8_15    (req_name_chars_8_15),
      .req_name_chars_16_18   (req_name_chars_16_18),
      .rsp_valid              (rsp_valid),
      .rsp_status             (rsp_status),
      .rsp_removed_score      (rsp_removed_score),
      .rsp_removed_chars_0_7  (rsp_removed_chars_0_7),
      .rsp_removed_chars_8_15 (rsp_removed_chars_8_15),
      .rsp_removed_chars_16_18(rsp_removed_chars_16_18),
      .rsp_occupancy          (rsp_occupancy)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic logic [63:0] name_byte_keep(input int first_byte, input int nbytes);
      logic [63:0] keep;
      keep = '0;
      for (int b = 0; b < nbytes; b++) begin
         if (first_byte + b < NAME_CHARS) begin
            keep[8*b +: 8] = 8'hFF;
         end
      end
      return keep;
   endfunction

   function automatic queue_outcome_type predict_queue_outcome(input logic op,
                                                               input entry_type item);
      queue_outcome_type outcome;
      int best;
      outcome = '{status: STATUS_INSERTED, score: '0, chars_low: '0, chars_mid: '0,
                  chars_high: '0, occupancy: '0};
      if (op == OP_INSERT) begin
         if (held_count >= DEPTH) begin
            outcome.status = STATUS_FULL;
         end else begin
            item.chars_low  = item.chars_low & name_byte_keep(0, 8);
            item.chars_mid  = item.chars_mid & name_byte_keep(8, 8);
            item.chars_high = item.chars_high & 24'(name_byte_keep(16, 3));
            held_entries[held_count] = item;
            held_count++;
         end
      end else if (held_count == 0) begin
         outcome.status = STATUS_EMPTY;
      end else begin
         best = 0;
         for (int i = 1; i < held_count; i++) begin
            if ($signed(held_entries[i].score) < $signed(held_entries[best].score)) begin
               best = i;
            end
         end
         outcome.status     = STATUS_REMOVED;
         outcome.score      = held_entries[best].score;
         outcome.chars_low  = held_entries[best].chars_low;
         outcome.chars_mid  = held_entries[best].chars_mid;
         outcome.chars_high = held_entries[best].chars_high;
         for (int i = best; i + 1 < held_count; i++) begin
            held_entries[i] = held_entries[i + 1];
         end
         held_count--;
      end
      outcome.occupancy = 5'(held_count);
      return outcome;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t ns: mismatch in %s: got %h, expected %h", $time, what, got, want);
      error_count++;
   endtask

   // Called at a rising edge; returns at the edge that accepts the beat.
   task automatic issue_command(input logic op, input logic signed [15:0] score,
                                input logic [63:0] c_low, input logic [63:0] c_mid,
                                input logic [23:0] c_high);
      int                gap;
      entry_type         item;
      queue_outcome_type outcome;
      gap = back_to_back ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start                <= 1'b1;
      req_opcode           <= op;
      req_score            <= score;
      req_name_chars_0_7   <= c_low;
      req_name_chars_8_15  <= c_mid;
      req_name_chars_16_18 <= c_high;
      do @(posedge clock); while (busy);
      item    = '{score: score, chars_low: c_low, chars_mid: c_mid, chars_high: c_high};
      outcome = predict_queue_outcome(op, item);
      expected_outcomes.push_back(outcome);
      case (outcome.status)
         STATUS_INSERTED: inserts_done++;
         STATUS_REMOVED:  removes_done++;
         STATUS_FULL:     full_refusals++;
         default:         empty_removes++;
      endcase
   endtask

   always @(posedge clock) begin
      queue_outcome_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_outcomes.size() == 0) begin
            report_mismatch("unexpected result beat", 64'(rsp_status), '0);
         end else begin
            want = expected_outcomes.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", 64'(rsp_status), 64'(want.status));
            if (rsp_removed_score !== want.score)
               report_mismatch("removed score", 64'(rsp_removed_score), 64'(want.score));
            if (rsp_removed_chars_0_7 !== want.chars_low)
               report_mismatch("name bytes 0-7", rsp_removed_chars_0_7, want.chars_low);
            if (rsp_removed_chars_8_15 !== want.chars_mid)
               report_mismatch("name bytes 8-15", rsp_removed_chars_8_15, want.chars_mid);
            if (rsp_removed_chars_16_18 !== want.chars_high)
               report_mismatch("name bytes 16-18", 64'(rsp_removed_chars_16_18),
                               64'(want.chars_high));
            if (rsp_occupancy !== want.occupancy)
               report_mismatch("occupancy", 64'(rsp_occupancy), 64'(want.occupancy));
         end
      end
   end

   function automatic logic [63:0] random_chunk();
      return {$urandom, $urandom};
   endfunction

   task automatic test_remove_from_empty();
      issue_command(OP_REMOVE, 16'sh1234, random_chunk(), random_chunk(), 24'hABCDEF);
   endtask

   task automatic test_fill_to_capacity();
      logic signed [15:0] scores [DEPTH];
      scores = '{16'sh7FFF, 16'sh8000, 16'sd0, -16'sd1, 16'sd5, 16'sd5, 16'sd5, 16'sd1,
                 16'sh8000, 16'sh7FFF, 16'sd100, -16'sd100, 16'sd5, 16'sd0, -16'sd1, 16'sd2};
      issue_command(OP_INSERT, scores[0], '1, '1, '1);
      issue_command(OP_INSERT, scores[1], '0, '0, '0);
      issue_command(OP_INSERT, scores[2], {8{8'hAA}}, {8{8'h55}}, {3{8'hAA}});
      issue_command(OP_INSERT, scores[3], {8{8'h55}}, {8{8'hAA}}, {3{8'h55}});
      for (int i = 4; i < DEPTH; i++) begin
         issue_command(OP_INSERT, scores[i], random_chunk(), random_chunk(), 24'($urandom));
      end
      issue_command(OP_INSERT, 16'sd7, random_chunk(), random_chunk(), 24'($urandom));
   endtask

   task automatic test_stable_order();
      for (int i = 0; i < 5; i++) begin
         issue_command(OP_REMOVE, 16'($urandom), random_chunk(), random_chunk(),
                       24'($urandom));
      end
   endtask

   task automatic test_random_traffic(input int beats);
      int                 remove_pct;
      logic               op;
      logic signed [15:0] score;
      remove_pct = 50;
      for (int k = 0; k < beats; k++) begin
         if (k % 100 == 0) begin
            case ($urandom_range(0, 2))
               0:       remove_pct = 20;
               1:       remove_pct = 50;
               default: remove_pct = 80;
            endcase
            back_to_back = ($urandom_range(0, 3) == 0);
         end
         op = ($urandom_range(0, 99) < remove_pct) ? OP_REMOVE : OP_INSERT;
         case ($urandom_range(0, 3))
            0:       score = 16'($urandom_range(0, 6)) - 16'sd3;
            1:       score = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default: score = 16'($urandom);
         endcase
         issue_command(op, score, random_chunk(), random_chunk(), 24'($urandom));
      end
      back_to_back = 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_remove_from_empty();
      test_fill_to_capacity();
      test_stable_order();
      test_random_traffic(1500);
      start <= 1'b0;
      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (2 * DEPTH + 8) @(posedge clock);
      $display("Covered %0d inserts, %0d removes, %0d refused inserts on a full store,",
               inserts_done, removes_done, full_refusals);
      $display("and %0d removes on an empty store, with ties and extreme scores.",
               empty_removes);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("Run timed out with %0d results outstanding.", expected_outcomes.size());
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/smpq_pkg.sv
src/smpq_ram.sv
src/smpq_min_unit.sv
src/stable_min_priority_queue.sv
verif/tb_stable_min_priority_queue.sv
